### sv/lkvc_pkg.sv
// Package for the LRU key-value cache: widths, request codes, controller
// states, datapath operations and the command/status structs.
// No dependencies.
package lkvc_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_PUT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_SCAN,
        S_RESP
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TOUCH_HIT,
        OP_UPDATE_HIT,
        OP_REMOVE_HIT,
        OP_REPLACE_LRU,
        OP_INSERT_FRESH,
        OP_INSERT_SCAN
    } op_t;

    typedef struct packed {
        logic capture;
        logic match;
        op_t  op;
        logic scan_start;
        logic scan_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_put;
        logic hit;
        logic full;
        logic over;
        logic holes;
        logic scan_free;
    } ctl_stat_t;

endpackage

### sv/lkvc_datapath.sv
// Datapath of the LRU key-value cache: tag flops, valid bits, recency ranks,
// value memory, capacity register and match logic.
// Depends on lkvc_pkg.
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lkvc_pkg::ctl_cmd_t              cmd,
    output lkvc_pkg::ctl_stat_t             stat,
    input  logic                            cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]      cfg_capacity,
    input  logic                            req_type,
    input  logic signed [lkvc_pkg::KEY_W-1:0] key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] value,
    output logic                            found,
    output logic signed [lkvc_pkg::VAL_W-1:0] read_value
);
    import lkvc_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int RANK_W = IDX_W;
    localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic              req_type_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [CAP_W-1:0]  cap_reg;

    logic              valid_reg [ENTRIES];
    logic [RANK_W-1:0] rank_reg  [ENTRIES];
    logic [KEY_W-1:0]  keys_reg  [ENTRIES];
    logic [VAL_W-1:0]  val_mem   [ENTRIES];
    logic [VAL_W-1:0]  rdata_reg;

    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  hwm_reg;
    logic [IDX_W-1:0]  scan_idx_reg;

    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [RANK_W-1:0] hit_rank_reg;
    logic [IDX_W-1:0]  lru_idx_reg;

    logic              hit_any;
    logic [IDX_W-1:0]  hit_idx;
    logic [RANK_W-1:0] hit_rank;
    logic [IDX_W-1:0]  lru_idx;

    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  occ_ext;
    logic [CMP_W-1:0]  ent_ext;
    logic [CMP_W-1:0]  eff_cap;

    logic [IDX_W-1:0]  tgt_idx;
    logic [OCC_W-1:0]  tgt_rank;
    logic              do_touch;
    logic              do_remove;
    logic              do_insert;
    logic              do_fresh;
    logic              key_wr;
    logic              val_wr;

    // parallel tag compare; hit and LRU vectors are one-hot, so OR-encode
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        hit_rank = '0;
        lru_idx  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && keys_reg[i] == key_reg)
            begin
                hit_any  = 1'b1;
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (valid_reg[i] && OCC_W'(rank_reg[i]) == occ_reg - OCC_W'(1))
            begin
                lru_idx = lru_idx | IDX_W'(i);
            end
        end
    end

    // clamp capacity to 1..ENTRIES
    always_comb
    begin
        cap_ext = CMP_W'(cap_reg);
        occ_ext = CMP_W'(occ_reg);
        ent_ext = CMP_W'(ENTRIES);
        if (cap_reg == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > ent_ext)
            eff_cap = ent_ext;
        else
            eff_cap = cap_ext;
    end

    always_comb
    begin
        stat.is_put    = (req_type_reg == REQ_PUT);
        stat.hit       = hit_reg;
        stat.full      = (occ_ext >= eff_cap);
        stat.over      = (occ_ext > eff_cap);
        stat.holes     = (hwm_reg != occ_reg);
        stat.scan_free = !valid_reg[scan_idx_reg];
    end

    always_comb
    begin
        tgt_idx   = hit_idx_reg;
        tgt_rank  = OCC_W'(hit_rank_reg);
        do_touch  = 1'b0;
        do_remove = 1'b0;
        do_insert = 1'b0;
        do_fresh  = 1'b0;
        key_wr    = 1'b0;
        val_wr    = 1'b0;
        case (cmd.op)
            OP_TOUCH_HIT:
            begin
                do_touch = 1'b1;
            end
            OP_UPDATE_HIT:
            begin
                do_touch = 1'b1;
                val_wr   = 1'b1;
            end
            OP_REMOVE_HIT:
            begin
                do_remove = 1'b1;
            end
            OP_REPLACE_LRU:
            begin
                tgt_idx  = lru_idx_reg;
                tgt_rank = occ_reg - OCC_W'(1);
                do_touch = 1'b1;
                key_wr   = 1'b1;
                val_wr   = 1'b1;
            end
            OP_INSERT_FRESH:
            begin
                tgt_idx   = hwm_reg[IDX_W-1:0];
                tgt_rank  = occ_reg;
                do_touch  = 1'b1;
                do_insert = 1'b1;
                do_fresh  = 1'b1;
                key_wr    = 1'b1;
                val_wr    = 1'b1;
            end
            OP_INSERT_SCAN:
            begin
                tgt_idx   = scan_idx_reg;
                tgt_rank  = occ_reg;
                do_touch  = 1'b1;
                do_insert = 1'b1;
                key_wr    = 1'b1;
                val_wr    = 1'b1;
            end
            default:
            begin
                do_touch = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            occ_reg      <= '0;
            hwm_reg      <= '0;
            scan_idx_reg <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            hit_rank_reg <= '0;
            lru_idx_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_capacity;
            if (cmd.match)
            begin
                hit_reg      <= hit_any;
                hit_idx_reg  <= hit_idx;
                hit_rank_reg <= hit_rank;
                lru_idx_reg  <= lru_idx;
            end
            if (cmd.scan_start)
                scan_idx_reg <= '0;
            else if (cmd.scan_step)
                scan_idx_reg <= scan_idx_reg + 1'b1;

            for (int i = 0; i < ENTRIES; i++)
            begin
                if (do_touch && valid_reg[i] && OCC_W'(rank_reg[i]) < tgt_rank)
                    rank_reg[i] <= rank_reg[i] + 1'b1;
                if (do_remove && valid_reg[i] && OCC_W'(rank_reg[i]) > tgt_rank)
                    rank_reg[i] <= rank_reg[i] - 1'b1;
            end
            if (do_touch)
                rank_reg[tgt_idx] <= '0;
            if (do_remove)
            begin
                rank_reg[tgt_idx]  <= '0;
                valid_reg[tgt_idx] <= 1'b0;
                occ_reg            <= occ_reg - 1'b1;
            end
            if (do_insert)
            begin
                valid_reg[tgt_idx] <= 1'b1;
                occ_reg            <= occ_reg + 1'b1;
            end
            if (do_fresh)
                hwm_reg <= hwm_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_type_reg <= req_type;
            key_reg      <= key;
            value_reg    <= value;
        end
        if (key_wr)
            keys_reg[tgt_idx] <= key_reg;
    end

    always_ff @(posedge clk)
    begin
        if (val_wr)
            val_mem[tgt_idx] <= value_reg;
        rdata_reg <= val_mem[hit_idx_reg];
    end

    assign found      = hit_reg;
    assign read_value = hit_reg ? rdata_reg : {VAL_W{1'b1}};

endmodule

### sv/lkvc_ctrl.sv
// Controller of the LRU key-value cache: sequences match, update, eviction
// and free-slot scan steps for one request at a time.
// Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 result_valid,
    output lkvc_pkg::ctl_cmd_t   cmd,
    input  lkvc_pkg::ctl_stat_t  stat
);
    import lkvc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.capture    = 1'b0;
        cmd.match      = 1'b0;
        cmd.op         = OP_NONE;
        cmd.scan_start = 1'b0;
        cmd.scan_step  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!stat.is_put)
                begin
                    cmd.op     = stat.hit ? OP_TOUCH_HIT : OP_NONE;
                    state_next = S_RESP;
                end
                else if (stat.hit && !stat.over)
                begin
                    cmd.op     = OP_UPDATE_HIT;
                    state_next = S_IDLE;
                end
                else if (stat.hit)
                begin
                    // drop the old copy, then match again to evict
                    cmd.op     = OP_REMOVE_HIT;
                    state_next = S_MATCH;
                end
                else if (stat.full)
                begin
                    cmd.op     = OP_REPLACE_LRU;
                    state_next = S_IDLE;
                end
                else if (!stat.holes)
                begin
                    cmd.op     = OP_INSERT_FRESH;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_free)
                begin
                    cmd.op     = OP_INSERT_SCAN;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = (state_reg == S_RESP);

endmodule

### sv/lru_key_value_cache_unit.sv
// Fully associative key-value cache with least-recently-used replacement, up
// to ENTRIES entries, cleared at reset with no clearing pass. One request is
// taken at a time: start is accepted when busy is low. A get returns found and
// read_value on a one-cycle result_valid strobe in the response state, after
// the match and execute states, and frees the block in the cycle after the
// strobe; the receiver cannot stall it. A put returns nothing and steps through
// match, then update. A put whose key is present while capacity sits below
// occupancy adds a remove and a rematch step. A put that adds a key after
// entries were removed that way scans the valid bits one per cycle for a free
// slot. capacity is to be written through cfg_valid/cfg_ready while idle; the
// user is bound to that, the block itself does not enforce it. 0 acts as 1,
// above ENTRIES as ENTRIES.
module lru_key_value_cache_unit #(
    parameter int ENTRIES = lkvc_pkg::DEF_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              req_type,
    input  logic signed [lkvc_pkg::KEY_W-1:0] key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] value,
    output logic                              result_valid,
    output logic                              found,
    output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]        cfg_capacity
);
    import lkvc_pkg::*;

    ctl_cmd_t  cmd;
    ctl_stat_t stat;
    logic      cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    lkvc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .cmd          (cmd),
        .stat         (stat)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_capacity (cfg_capacity),
        .req_type     (req_type),
        .key          (key),
        .value        (value),
        .found        (found),
        .read_value   (read_value)
    );

`ifndef NO_ASSERTIONS
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_result_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd.match, 2))
        else $error("result without a preceding match step");

    a_fresh_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INSERT_FRESH) |-> (!stat.holes && !stat.full))
        else $error("fresh insert with holes present or store full");
`endif

endmodule
